// ===== sv/ula_pkg.sv =====
// Shared constants, widths and register codes for the ultrasonic level averager.
// No dependencies; compiled before every other file.
`default_nettype none

package ula_pkg;

	localparam int RING_DEPTH_DEF = 10;

	localparam int ECHO_W     = 20;
	localparam int DIST_W     = 21;
	localparam int LEVEL_W    = 17;
	localparam int COUNT_W    = 4;
	localparam int CFG_W      = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int DISTCFG_W  = 20;
	localparam int CAP_W      = 16;

	localparam int DIST_MUL_W = 11;
	localparam int DIST_SHIFT = 10;
	localparam int SCALE_W    = ECHO_W + DIST_MUL_W;
	localparam logic [DIST_MUL_W-1:0] DIST_MUL = 11'd1755;

	// divider: dividend as wide as (mean - empty) * capacity, divisor as wide as |full - empty|
	localparam int NUM_W = DIST_W + CAP_W;
	localparam int DVS_W = DISTCFG_W;

	localparam logic [DISTCFG_W-1:0] FULL_RST  = 20'd1280;
	localparam logic [DISTCFG_W-1:0] EMPTY_RST = 20'd11776;
	localparam logic [CAP_W-1:0]     CAP_RST   = 16'd776;

	localparam logic signed [LEVEL_W-1:0] LEVEL_NONE = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL  = 2'd0,
		REG_EMPTY = 2'd1,
		REG_CAP   = 2'd2
	} reg_idx_t;

endpackage

`default_nettype wire

// ===== sv/ula_ifs.sv =====
// Stream interfaces: echo width samples in, tank level results out.
// Depends on ula_pkg for field widths.
`default_nettype none

interface ula_echo_if import ula_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ECHO_W-1:0] echo_us;

	modport source (output valid, output echo_us, input ready);
	modport sink (input valid, input echo_us, output ready);
endinterface

interface ula_level_if import ula_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [LEVEL_W-1:0] level_gallons;
	logic [DIST_W-1:0]         mean_distance_q8;
	logic [COUNT_W-1:0]        valid_count;

	modport source (output valid, output level_gallons, output mean_distance_q8,
		output valid_count, input ready);
	modport sink (input valid, input level_gallons, input mean_distance_q8,
		input valid_count, output ready);
endinterface

`default_nettype wire

// ===== sv/ula_ram.sv =====
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module ula_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ultrasonic_level_averager.sv =====
// Ultrasonic tank level averager: echo width to distance, ring average, level mapping.
// Depends on ula_pkg, ula_echo_if, ula_level_if and ula_ram.
//
// Usage:
//   echo  : one transaction per echo width in microseconds (zero = no echo).
//   level : one transaction per echo: level in gallons (-1 when unknown or below
//           empty), mean distance of the nonzero samples in 1/256 inch and their count.
//   cfg   : cfg_we/cfg_index/cfg_data write full distance, empty distance and
//           capacity; write only while no transaction is in flight.
// An accepted echo is scaled, written to the ring, summed, divided to the mean, then
// mapped and divided to the level; both divisions are skipped when no sample is valid,
// the second also when the level is settled without it. The ring is summed one RAM
// read a cycle, and one restoring divider, one quotient bit a cycle, serves both in turn.
// echo.ready is high only while the block is idle with no finished result held back:
// one echo at a time; the next is not taken before the current result is finished.
// A finished result sits in an output register; the next echo is accepted while it
// waits, and the block holds its next result until level.ready takes the first.
// Reset empties the ring (valid bits cleared), rewinds the write slot, drops any
// pending result and restores the default tank registers.
`default_nettype none

module ultrasonic_level_averager import ula_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	ula_echo_if.sink             echo,
	ula_level_if.source          level
);

	localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = DIST_W + CNT_W;
	localparam int STEP_W = $clog2(NUM_W + 1);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SCALE = 10'b0000000010,
		S_WRITE = 10'b0000000100,
		S_SUM   = 10'b0000001000,
		S_LOAD1 = 10'b0000010000,
		S_DIV1  = 10'b0000100000,
		S_DIFF  = 10'b0001000000,
		S_MUL   = 10'b0010000000,
		S_LOAD2 = 10'b0100000000,
		S_DIV2  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [DISTCFG_W-1:0] full_q;
	logic [DISTCFG_W-1:0] empty_q;
	logic [CAP_W-1:0]     cap_q;

	logic [IDX_W-1:0]      slot_q;
	logic [RING_DEPTH-1:0] vbits_q;
	logic [CNT_W-1:0]      idx_q;
	logic [STEP_W-1:0]     steps_q;
	logic                  rd_vld_s1;
	logic                  vbit_s1;
	logic                  out_vld_q;
	logic                  done_q;

	logic [ECHO_W-1:0]         echo_q;
	logic [DIST_W-1:0]         dist_q;
	logic [SUM_W-1:0]          sum_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [DVS_W-1:0]          rem_q;
	logic [NUM_W-1:0]          quo_q;
	logic [DVS_W-1:0]          dvs_q;
	logic [DIST_W-1:0]         mean_q;
	logic [DIST_W-1:0]         mag_q;
	logic                      num_neg_q;
	logic [NUM_W-1:0]          prod_q;
	logic signed [LEVEL_W-1:0] level_q;

	logic signed [LEVEL_W-1:0] out_level_q;
	logic [DIST_W-1:0]         out_mean_q;
	logic [COUNT_W-1:0]        out_count_q;

	logic [SCALE_W-1:0] dist_prod;
	logic               ram_we;
	logic               ram_re;
	logic [DIST_W-1:0]  ram_rdata;
	logic               sum_last;
	logic               acc_en;
	logic [DVS_W:0]     shl;
	logic [DVS_W+1:0]   trial;
	logic               q_bit;
	logic [DVS_W-1:0]   rem_nx;
	logic [NUM_W-1:0]   quo_nx;
	logic [DIST_W:0]    mean_diff;
	logic [DIST_W-1:0]  mean_mag;
	logic [DISTCFG_W:0] den;
	logic               den_neg;
	logic [DVS_W-1:0]   den_abs;
	logic [NUM_W-1:0]   map_prod;
	logic               out_free;
	logic               div_last;

	assign dist_prod = SCALE_W'(echo_q) * SCALE_W'(DIST_MUL);
	assign sum_last  = (idx_q == CNT_W'(RING_DEPTH));
	assign ram_we    = (state_q == S_WRITE);
	assign ram_re    = (state_q == S_SUM) && !sum_last;
	assign acc_en    = rd_vld_s1 && vbit_s1 && (ram_rdata != '0);

	ula_ram #(
		.WIDTH (DIST_W),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (dist_q),
		.re    (ram_re),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// one restoring division step
	assign shl    = {rem_q, quo_q[NUM_W-1]};
	assign trial  = {1'b0, shl} - {2'b00, dvs_q};
	assign q_bit  = ~trial[DVS_W+1];
	assign rem_nx = q_bit ? trial[DVS_W-1:0] : shl[DVS_W-1:0];
	assign quo_nx = {quo_q[NUM_W-2:0], q_bit};
	assign div_last = (steps_q == STEP_W'(1));

	assign mean_diff = {1'b0, quo_q[DIST_W-1:0]} - {2'b00, empty_q};
	assign mean_mag  = mean_diff[DIST_W] ? DIST_W'(-mean_diff) : mean_diff[DIST_W-1:0];
	assign den       = {1'b0, full_q} - {1'b0, empty_q};
	assign den_neg   = den[DISTCFG_W];
	assign den_abs   = den_neg ? DVS_W'(-den) : den[DVS_W-1:0];
	assign map_prod  = NUM_W'(mag_q) * NUM_W'(cap_q);

	assign out_free = !out_vld_q || level.ready;

	assign echo.ready             = (state_q == S_IDLE) && !done_q;
	assign level.valid            = out_vld_q;
	assign level.level_gallons    = out_level_q;
	assign level.mean_distance_q8 = out_mean_q;
	assign level.valid_count      = out_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			full_q    <= FULL_RST;
			empty_q   <= EMPTY_RST;
			cap_q     <= CAP_RST;
			slot_q    <= '0;
			vbits_q   <= '0;
			idx_q     <= '0;
			steps_q   <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FULL:  full_q  <= cfg_data[DISTCFG_W-1:0];
					REG_EMPTY: empty_q <= cfg_data[DISTCFG_W-1:0];
					REG_CAP:   cap_q   <= cfg_data[CAP_W-1:0];
					default: ;
				endcase
			end

			rd_vld_s1 <= ram_re;

			if (done_q && out_free) begin
				out_vld_q <= 1'b1;
				done_q    <= 1'b0;
			end else if (level.ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (echo.valid && !done_q) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_WRITE;
				end
				S_WRITE: begin
					vbits_q[slot_q] <= 1'b1;
					slot_q <= (slot_q == IDX_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					idx_q   <= '0;
					state_q <= S_SUM;
				end
				S_SUM: begin
					if (sum_last) begin
						state_q <= S_LOAD1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_LOAD1: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						steps_q <= STEP_W'(SUM_W);
						state_q <= S_DIV1;
					end
				end
				S_DIV1: begin
					steps_q <= steps_q - 1'b1;
					if (div_last) begin
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_LOAD2;
				end
				S_LOAD2: begin
					if (den_abs == '0 || prod_q == '0 || num_neg_q != den_neg) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						steps_q <= STEP_W'(NUM_W);
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					steps_q <= steps_q - 1'b1;
					if (div_last) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		vbit_s1 <= vbits_q[idx_q[IDX_W-1:0]];

		if (state_q == S_IDLE && echo.valid && !done_q) begin
			echo_q <= echo.echo_us;
		end
		if (state_q == S_SCALE) begin
			dist_q <= dist_prod[DIST_SHIFT +: DIST_W];
		end
		if (state_q == S_WRITE) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (acc_en) begin
			sum_q <= sum_q + SUM_W'(ram_rdata);
			cnt_q <= cnt_q + 1'b1;
		end

		if (state_q == S_LOAD1) begin
			mean_q  <= '0;
			level_q <= LEVEL_NONE;
			rem_q   <= '0;
			quo_q   <= NUM_W'(sum_q) << (NUM_W - SUM_W);
			dvs_q   <= DVS_W'(cnt_q);
		end
		if (state_q == S_DIV1 || state_q == S_DIV2) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
		if (state_q == S_DIFF) begin
			mean_q    <= quo_q[DIST_W-1:0];
			mag_q     <= mean_mag;
			num_neg_q <= mean_diff[DIST_W];
		end
		if (state_q == S_MUL) begin
			prod_q <= map_prod;
		end
		if (state_q == S_LOAD2) begin
			if (den_abs == '0) begin
				level_q <= LEVEL_NONE;
			end else if (prod_q == '0) begin
				level_q <= '0;
			end else begin
				level_q <= LEVEL_NONE;
			end
			rem_q <= '0;
			quo_q <= prod_q;
			dvs_q <= den_abs;
		end
		if (state_q == S_DIV2 && div_last) begin
			if (quo_nx > NUM_W'(cap_q)) begin
				level_q <= {1'b0, cap_q};
			end else begin
				level_q <= {1'b0, quo_nx[CAP_W-1:0]};
			end
		end

		if (done_q && out_free) begin
			out_level_q <= level_q;
			out_mean_q  <= mean_q;
			out_count_q <= COUNT_W'(cnt_q);
		end
	end

endmodule

`default_nettype wire
